/* rtl/sqc_pkg.sv */
// Package for the SARSA chain Q-update block: field widths, transfer structs,
// register indexes, reset values and the controller state type.
// Depends on nothing; imported by the Q-update block, its checker and its testbench.
`default_nettype none

package sqc_pkg;

    localparam int DEFAULT_CHAIN_LENGTH = 5;

    localparam int Q_W       = 24;
    localparam int FRAC_W    = 16;
    localparam int THR_W     = 17;
    localparam int REWARD_W  = 8;
    localparam int DRAW_W    = 16;
    localparam int STATE_OUT_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [THR_W-1:0]          RST_THRESHOLD = 17'd65536;
    localparam logic [FRAC_W-1:0]         RST_LEARN     = 16'd58982;
    localparam logic [FRAC_W-1:0]         RST_DISCOUNT  = 16'd58982;
    localparam logic signed [REWARD_W-1:0] RST_END_RWD  = 8'sd10;
    localparam logic signed [REWARD_W-1:0] RST_FWD_RWD  = 8'sd0;
    localparam logic signed [REWARD_W-1:0] RST_RET_RWD  = 8'sd2;

    localparam logic ACT_A = 1'b0;
    localparam logic ACT_B = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_LEARN     = 3'd1,
        CFG_DISCOUNT  = 3'd2,
        CFG_END_RWD   = 3'd3,
        CFG_FWD_RWD   = 3'd4,
        CFG_RET_RWD   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [DRAW_W-1:0] explore_draw;
        logic              random_action;
        logic              tie_pick;
    } t_cmd;

    typedef struct packed {
        logic [STATE_OUT_W-1:0]       from_state;
        logic                         taken_action;
        logic signed [REWARD_W-1:0]   step_reward;
        logic [STATE_OUT_W-1:0]       to_state;
        logic                         chosen_next;
        logic signed [Q_W-1:0]        updated_value;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL1,
        ST_DIFF,
        ST_MUL2,
        ST_WB
    } t_state;

endpackage

`default_nettype wire

/* rtl/sqc_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module sqc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 5
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/sarsa_chain_q_update.sv */
// Sequencing: a new step is taken only in the idle state, after the last write-back; the
// two table row reads, two multiplies and the write-back of the shared row memory are
// done in sequence for each step, and the result strobe follows the write-back.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every table row
// in turn while busy is high. The receiver cannot stall results.
`default_nettype none

module sarsa_chain_q_update #(
    parameter int CHAIN_LENGTH = sqc_pkg::DEFAULT_CHAIN_LENGTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire sqc_pkg::t_cmd                      i_cmd,
    output logic                                    o_done,
    output sqc_pkg::t_result                        o_result,
    input  wire logic                               i_cfg_we,
    input  wire logic [sqc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [sqc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import sqc_pkg::*;

    localparam int SW    = $clog2(CHAIN_LENGTH);
    localparam int ROW_W = 2 * Q_W;
    localparam int P1_W  = FRAC_W + 1 + Q_W;
    localparam int D_W   = Q_W + 2;
    localparam int P2_W  = FRAC_W + 1 + D_W;
    localparam int NQ_W  = Q_W + 4;
    localparam logic [SW-1:0] LAST = SW'(CHAIN_LENGTH - 1);

    // Configuration registers.
    logic [THR_W-1:0]           r_thr;
    logic [FRAC_W-1:0]          r_learn;
    logic [FRAC_W-1:0]          r_discount;
    logic signed [REWARD_W-1:0] r_end_rwd;
    logic signed [REWARD_W-1:0] r_fwd_rwd;
    logic signed [REWARD_W-1:0] r_ret_rwd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= RST_THRESHOLD;
            r_learn    <= RST_LEARN;
            r_discount <= RST_DISCOUNT;
            r_end_rwd  <= RST_END_RWD;
            r_fwd_rwd  <= RST_FWD_RWD;
            r_ret_rwd  <= RST_RET_RWD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_thr      <= i_cfg_wdata;
                CFG_LEARN:     r_learn    <= i_cfg_wdata[FRAC_W-1:0];
                CFG_DISCOUNT:  r_discount <= i_cfg_wdata[FRAC_W-1:0];
                CFG_END_RWD:   r_end_rwd  <= i_cfg_wdata[REWARD_W-1:0];
                CFG_FWD_RWD:   r_fwd_rwd  <= i_cfg_wdata[REWARD_W-1:0];
                CFG_RET_RWD:   r_ret_rwd  <= i_cfg_wdata[REWARD_W-1:0];
                default: ;
            endcase
        end
    end

    // Controller and persistent learner state.
    t_state          r_fsm, n_fsm;
    logic [SW-1:0]   r_state;
    logic            r_action;
    logic [SW-1:0]   r_clr_idx;
    logic            r_done;
    t_result         r_result, n_result;

    // Per-step working registers.
    logic [SW-1:0]              r_s, r_ns;
    logic                       r_a, r_na;
    logic signed [REWARD_W-1:0] r_r;
    t_cmd                       r_cmd;
    logic [ROW_W-1:0]           r_row_s;
    logic signed [P1_W-1:0]     r_prod1;
    logic signed [D_W-1:0]      r_d;
    logic signed [P2_W-1:0]     r_prod2;

    // Row memory: bits [Q_W-1:0] hold action A, the upper half action B.
    logic              ram_we;
    logic [SW-1:0]     ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [SW-1:0]     ram_raddr;
    logic [ROW_W-1:0]  ram_rdata;

    sqc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CHAIN_LENGTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic accept;
    assign accept = start && !busy;

    // Transition of the present state.
    logic [SW-1:0]              step_ns;
    logic signed [REWARD_W-1:0] step_r;

    always_comb begin
        if (r_action == ACT_A) begin
            if (r_state == LAST) begin
                step_ns = r_state;
                step_r  = r_end_rwd;
            end else begin
                step_ns = SW'(r_state + 1'b1);
                step_r  = r_fwd_rwd;
            end
        end else begin
            step_ns = '0;
            step_r  = r_ret_rwd;
        end
    end

    // Epsilon-greedy choice in the reached state and the discounted product.
    logic signed [Q_W-1:0] nq_a, nq_b, qn_sel;
    logic                  explore, na_sel;

    always_comb begin
        nq_a    = ram_rdata[Q_W-1:0];
        nq_b    = ram_rdata[ROW_W-1:Q_W];
        explore = {1'b0, r_cmd.explore_draw} < r_thr;
        if (explore) begin
            na_sel = r_cmd.random_action;
        end else if (nq_a > nq_b) begin
            na_sel = ACT_A;
        end else if (nq_b > nq_a) begin
            na_sel = ACT_B;
        end else begin
            na_sel = r_cmd.tie_pick;
        end
        qn_sel = (na_sel == ACT_B) ? nq_b : nq_a;
    end

    // Temporal difference: r*4096 + round(gamma*Q') - Q.
    logic signed [Q_W-1:0]   q_old;
    logic signed [P1_W-1:0]  p1_rnd;
    logic signed [D_W-1:0]   d_calc;

    always_comb begin
        q_old  = (r_a == ACT_B) ? r_row_s[ROW_W-1:Q_W] : r_row_s[Q_W-1:0];
        p1_rnd = r_prod1 + P1_W'(32768);
        d_calc = $signed({{(D_W-REWARD_W-12){r_r[REWARD_W-1]}}, r_r, 12'b0})
               + $signed({p1_rnd[P1_W-1], p1_rnd[P1_W-1:FRAC_W]})
               - $signed({{(D_W-Q_W){q_old[Q_W-1]}}, q_old});
    end

    // Update and saturation.
    logic signed [P2_W-1:0] p2_rnd;
    logic signed [NQ_W-1:0] nq_wide;
    logic signed [Q_W-1:0]  nq_sat;

    always_comb begin
        p2_rnd  = r_prod2 + P2_W'(32768);
        nq_wide = $signed({{(NQ_W-Q_W){q_old[Q_W-1]}}, q_old})
                + $signed({p2_rnd[P2_W-1], p2_rnd[P2_W-1:FRAC_W]});
        if (nq_wide[NQ_W-1:Q_W-1] == '0 || nq_wide[NQ_W-1:Q_W-1] == '1) begin
            nq_sat = nq_wide[Q_W-1:0];
        end else if (nq_wide[NQ_W-1]) begin
            nq_sat = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            nq_sat = {1'b0, {(Q_W-1){1'b1}}};
        end
    end

    // Next state.
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            ST_CLEAR: if (r_clr_idx == LAST) n_fsm = ST_IDLE;
            ST_IDLE:  if (start) n_fsm = ST_READ;
            ST_READ:  n_fsm = ST_MUL1;
            ST_MUL1:  n_fsm = ST_DIFF;
            ST_DIFF:  n_fsm = ST_MUL2;
            ST_MUL2:  n_fsm = ST_WB;
            ST_WB:    n_fsm = ST_IDLE;
            default:  n_fsm = ST_CLEAR;
        endcase
    end

    // Outputs of the controller.
    always_comb begin
        busy      = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = r_s;
        ram_wdata = r_row_s;
        ram_raddr = r_state;
        unique case (r_fsm)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_READ: begin
                ram_raddr = r_ns;
            end
            ST_WB: begin
                ram_we = 1'b1;
                if (r_a == ACT_B) begin
                    ram_wdata = {nq_sat, r_row_s[Q_W-1:0]};
                end else begin
                    ram_wdata = {r_row_s[ROW_W-1:Q_W], nq_sat};
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_result               = r_result;
        n_result.from_state    = STATE_OUT_W'(r_s);
        n_result.taken_action  = r_a;
        n_result.step_reward   = r_r;
        n_result.to_state      = STATE_OUT_W'(r_ns);
        n_result.chosen_next   = r_na;
        n_result.updated_value = nq_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= ST_CLEAR;
            r_state   <= '0;
            r_action  <= ACT_A;
            r_clr_idx <= '0;
            r_done    <= 1'b0;
        end else begin
            r_fsm  <= n_fsm;
            r_done <= (r_fsm == ST_WB);
            if (r_fsm == ST_CLEAR) begin
                r_clr_idx <= SW'(r_clr_idx + 1'b1);
            end
            if (r_fsm == ST_WB) begin
                r_state  <= r_ns;
                r_action <= r_na;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s   <= r_state;
            r_a   <= r_action;
            r_ns  <= step_ns;
            r_r   <= step_r;
            r_cmd <= i_cmd;
        end
        if (r_fsm == ST_READ) begin
            r_row_s <= ram_rdata;
        end
        if (r_fsm == ST_MUL1) begin
            r_na    <= na_sel;
            r_prod1 <= $signed({1'b0, r_discount}) * qn_sel;
        end
        if (r_fsm == ST_DIFF) begin
            r_d <= d_calc;
        end
        if (r_fsm == ST_MUL2) begin
            r_prod2 <= $signed({1'b0, r_learn}) * r_d;
        end
        if (r_fsm == ST_WB) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_done_after_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_fsm) == ST_WB && !busy))
        else $error("Result strobe without a preceding write-back.");

    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_fsm == ST_READ)
        else $error("Accepted transfer did not start a table read.");

    a_state_follows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.to_state == STATE_OUT_W'(r_state)
                    && o_result.chosen_next == r_action))
        else $error("Learner state disagrees with the delivered result.");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm == ST_CLEAR |-> !o_done)
        else $error("Result strobe during the clearing pass.");

endmodule

`default_nettype wire

/* test/sarsa_chain_q_update_checker.sv */
// Checker for the SARSA chain Q-update block: follows the configuration writes and the
// command and result transfers, predicts every step and compares the results field by field.
// Depends on sqc_pkg; instantiated by sarsa_chain_q_update_tb beside the block.
`timescale 1ns / 1ps

module sarsa_chain_q_update_checker #(
    parameter int CHAIN_LENGTH = sqc_pkg::DEFAULT_CHAIN_LENGTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic                           i_busy,
    input  wire sqc_pkg::t_cmd                  i_cmd,
    input  wire logic                           i_done,
    input  wire sqc_pkg::t_result               i_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [sqc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sqc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    import sqc_pkg::*;

    localparam longint Q_HI = (longint'(1) <<< (Q_W - 1)) - 1;
    localparam longint Q_LO = -(longint'(1) <<< (Q_W - 1));

    logic signed [Q_W-1:0]      q_table [2*CHAIN_LENGTH];
    int                         cur_state;
    logic                       cur_action;
    logic [THR_W-1:0]           thr_reg;
    logic [FRAC_W-1:0]          alpha_reg;
    logic [FRAC_W-1:0]          gamma_reg;
    logic signed [REWARD_W-1:0] end_rwd;
    logic signed [REWARD_W-1:0] fwd_rwd;
    logic signed [REWARD_W-1:0] ret_rwd;
    t_result                    predicted_steps[$];
    int                         fails = 0;

    assign o_fail_count = fails;

    // Multiply by an unsigned 0.16 fraction, round to nearest with ties upward.
    function automatic longint scale_q16(logic [FRAC_W-1:0] frac, longint v);
        longint f;
        f = frac;
        return (f * v + 32768) >>> 16;
    endfunction

    function automatic t_result sarsa_step(t_cmd c);
        int                         s;
        int                         ns;
        logic                       na;
        logic signed [REWARD_W-1:0] r;
        longint                     q;
        longint                     qn;
        longint                     d;
        longint                     nq;
        t_result                    res;
        s = cur_state % CHAIN_LENGTH;
        if (cur_action == ACT_A) begin
            if (s == CHAIN_LENGTH - 1) begin
                ns = s;
                r  = end_rwd;
            end else begin
                ns = s + 1;
                r  = fwd_rwd;
            end
        end else begin
            ns = 0;
            r  = ret_rwd;
        end
        if ({1'b0, c.explore_draw} < thr_reg) begin
            na = c.random_action;
        end else if (q_table[2*ns] > q_table[2*ns+1]) begin
            na = ACT_A;
        end else if (q_table[2*ns+1] > q_table[2*ns]) begin
            na = ACT_B;
        end else begin
            na = c.tie_pick;
        end
        // The next value is read before the write, which matters for the end-state self loop.
        q  = q_table[2*s + int'(cur_action)];
        qn = q_table[2*ns + int'(na)];
        d  = longint'(r) * 4096 + scale_q16(gamma_reg, qn) - q;
        nq = q + scale_q16(alpha_reg, d);
        if (nq > Q_HI) nq = Q_HI;
        if (nq < Q_LO) nq = Q_LO;
        q_table[2*s + int'(cur_action)] = nq[Q_W-1:0];
        res.from_state    = s[STATE_OUT_W-1:0];
        res.taken_action  = cur_action;
        res.step_reward   = r;
        res.to_state      = ns[STATE_OUT_W-1:0];
        res.chosen_next   = na;
        res.updated_value = nq[Q_W-1:0];
        cur_state  = ns;
        cur_action = na;
        return res;
    endfunction

    function automatic void check_field(string fname, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < 2*CHAIN_LENGTH; i++) q_table[i] = '0;
            cur_state  = 0;
            cur_action = ACT_A;
            thr_reg    = RST_THRESHOLD;
            alpha_reg  = RST_LEARN;
            gamma_reg  = RST_DISCOUNT;
            end_rwd    = RST_END_RWD;
            fwd_rwd    = RST_FWD_RWD;
            ret_rwd    = RST_RET_RWD;
            predicted_steps.delete();
        end else begin
            if (i_done) begin
                if (predicted_steps.size() == 0) begin
                    $error("result transfer with no step outstanding");
                    fails++;
                end else begin
                    want = predicted_steps.pop_front();
                    check_field("from_state", want.from_state, i_result.from_state);
                    check_field("taken_action", want.taken_action, i_result.taken_action);
                    check_field("step_reward", want.step_reward, i_result.step_reward);
                    check_field("to_state", want.to_state, i_result.to_state);
                    check_field("chosen_next", want.chosen_next, i_result.chosen_next);
                    check_field("updated_value", want.updated_value, i_result.updated_value);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD: thr_reg   = i_cfg_wdata[THR_W-1:0];
                    CFG_LEARN:     alpha_reg = i_cfg_wdata[FRAC_W-1:0];
                    CFG_DISCOUNT:  gamma_reg = i_cfg_wdata[FRAC_W-1:0];
                    CFG_END_RWD:   end_rwd   = i_cfg_wdata[REWARD_W-1:0];
                    CFG_FWD_RWD:   fwd_rwd   = i_cfg_wdata[REWARD_W-1:0];
                    CFG_RET_RWD:   ret_rwd   = i_cfg_wdata[REWARD_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) predicted_steps.push_back(sarsa_step(i_cmd));
        end
        o_pending <= predicted_steps.size();
    end

endmodule

/* test/sarsa_chain_q_update_tb.sv */
// Testbench top for the SARSA chain Q-update block: drives reset, register writes and
// directed and random step commands with random gaps, then reports the verdict.
// Depends on sqc_pkg, sarsa_chain_q_update and sarsa_chain_q_update_checker.
`timescale 1ns / 1ps

module sarsa_chain_q_update_tb;
    import sqc_pkg::*;

    localparam int CHAIN = DEFAULT_CHAIN_LENGTH;
    localparam int LIMIT = 200000;
    localparam int STEPS_PER_PHASE = 95;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [THR_W-1:0]           thr;
        logic [FRAC_W-1:0]          alpha;
        logic [FRAC_W-1:0]          gamma;
        logic signed [REWARD_W-1:0] end_r;
        logic signed [REWARD_W-1:0] fwd_r;
        logic signed [REWARD_W-1:0] ret_r;
    } t_setting;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_cmd                  i_cmd = '0;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    int                    pending;
    int                    fail_count;
    int                    cycles = 0;
    int                    burst = 0;

    always #1 i_clk = ~i_clk;

    sarsa_chain_q_update #(.CHAIN_LENGTH(CHAIN)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_done(o_done), .o_result(o_result), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    sarsa_chain_q_update_checker #(.CHAIN_LENGTH(CHAIN)) checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_cmd(i_cmd),
        .i_done(o_done), .i_result(o_result), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata), .o_pending(pending), .o_fail_count(fail_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(logic [DRAW_W-1:0] draw, logic act, logic tie);
        t_cmd c;
        c.explore_draw  = draw;
        c.random_action = act;
        c.tie_pick      = tie;
        return c;
    endfunction

    function automatic t_cmd rand_cmd();
        int   k;
        logic [DRAW_W-1:0] draw;
        k = $urandom_range(0, 15);
        if (k == 0) draw = '0;
        else if (k == 1) draw = '1;
        else draw = DRAW_W'($urandom_range(0, 65535));
        // Favor action A so that the walk often reaches the end of the chain.
        return make_cmd(draw, ($urandom_range(0, 9) < 7) ? ACT_A : ACT_B,
                        logic'($urandom_range(0, 1)));
    endfunction

    function automatic t_setting rand_setting();
        t_setting st;
        int       k;
        k = $urandom_range(0, 4);
        case (k)
            0: st.thr = '0;
            1: st.thr = 17'd65535;
            2: st.thr = 17'd65536;
            3: st.thr = '1;
            default: st.thr = THR_W'($urandom_range(0, 131071));
        endcase
        st.alpha = FRAC_W'($urandom);
        st.gamma = FRAC_W'($urandom);
        st.end_r = REWARD_W'($urandom);
        st.fwd_r = REWARD_W'($urandom);
        st.ret_r = REWARD_W'($urandom);
        return st;
    endfunction

    // Each transfer waits a random gap, with occasional runs of back-to-back commands.
    task automatic send(t_cmd c);
        int gap;
        if (burst > 0) begin
            gap = 0;
            burst--;
        end else begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 15) == 0) burst = $urandom_range(5, 25);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // Unused upper data bits carry random values; the registers must ignore them.
    task automatic apply_setting(t_setting st);
        logic [CFG_DATA_W-1:0] junk;
        wait_drained();
        junk = CFG_DATA_W'($urandom);
        put_reg(CFG_THRESHOLD, st.thr);
        put_reg(CFG_LEARN, {junk[16], st.alpha});
        put_reg(CFG_DISCOUNT, {junk[15], st.gamma});
        put_reg(CFG_END_RWD, {junk[8:0], st.end_r});
        put_reg(CFG_FWD_RWD, {junk[16:8], st.fwd_r});
        put_reg(CFG_RET_RWD, {junk[12:4], st.ret_r});
        put_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_setting fixed [5];
        fixed[0] = '{17'd65536, 16'd58982, 16'd58982, 8'sd10, 8'sd0, 8'sd2};
        fixed[1] = '{17'd0, 16'd65535, 16'd65535, 8'sd127, 8'sd127, 8'sd127};
        fixed[2] = '{17'd0, 16'd65535, 16'd65535, -8'sd128, -8'sd128, -8'sd128};
        fixed[3] = '{17'd131071, 16'd0, 16'd0, 8'sd5, -8'sd3, 8'sd1};
        fixed[4] = '{17'd32768, 16'd32768, 16'd49152, -8'sd7, 8'sd3, 8'sd1};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: always explore. Walk to the end, take the self loop, return.
        send(make_cmd(16'd0, ACT_A, 1'b0));
        send(make_cmd(16'd65535, ACT_A, 1'b1));
        send(make_cmd(16'd1, ACT_A, 1'b0));
        send(make_cmd(16'd32768, ACT_A, 1'b1));
        send(make_cmd(16'd0, ACT_B, 1'b0));
        send(make_cmd(16'd0, ACT_A, 1'b0));
        send(make_cmd(16'd65535, ACT_B, 1'b0));

        // Never explore: greedy choice, ties decided by the tie bit.
        apply_setting('{17'd0, 16'd58982, 16'd58982, 8'sd10, 8'sd0, 8'sd2});
        send(make_cmd(16'd0, ACT_B, 1'b1));
        send(make_cmd(16'd65535, ACT_A, 1'b0));
        send(make_cmd(16'd0, ACT_A, 1'b1));
        send(make_cmd(16'd65535, ACT_B, 1'b0));
        send(make_cmd(16'd0, ACT_B, 1'b1));
        send(make_cmd(16'd0, ACT_A, 1'b0));
        send(make_cmd(16'd65535, ACT_B, 1'b1));
        send(make_cmd(16'd0, ACT_A, 1'b0));

        // Threshold at the top draw: only the top draw exploits.
        apply_setting('{17'd65535, 16'd58982, 16'd58982, 8'sd10, 8'sd0, 8'sd2});
        send(make_cmd(16'd65535, ACT_B, 1'b0));
        send(make_cmd(16'd65534, ACT_B, 1'b1));
        send(make_cmd(16'd65535, ACT_A, 1'b1));
        send(make_cmd(16'd0, ACT_A, 1'b0));

        for (int p = 0; p < 8; p++) begin
            apply_setting(p < 5 ? fixed[p] : rand_setting());
            for (int n = 0; n < STEPS_PER_PHASE; n++) begin
                send(rand_cmd());
                if ($urandom_range(0, 49) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/sqc_pkg.sv
rtl/sqc_ram.sv
rtl/sarsa_chain_q_update.sv
test/sarsa_chain_q_update_checker.sv
test/sarsa_chain_q_update_tb.sv
